// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/prl_pkg.sv =====
`timescale 1ns / 1ps

package prl_pkg;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int KEY_W    = 16;
    localparam int PAY_W    = 16;
    localparam int STATUS_W = 3;

    localparam int CAPACITY_DEF     = 16;
    localparam int KEY_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT,
        MODE_DELETE_POS,
        MODE_FIND,
        MODE_SORT,
        MODE_READ_ALL,
        MODE_DELETE_KEY
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_BADPOS,
        ST_FULL,
        ST_NOKEY,
        ST_EMPTY
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_op;

endpackage

// ===== rtl/prl_req_if.sv =====
`timescale 1ns / 1ps

interface prl_req_if import prl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   key;
    logic [PAY_W-1:0]   payload;

    modport source (output valid, output mode, output position, output key,
                    output payload, input ready);
    modport sink   (input valid, input mode, input position, input key,
                    input payload, output ready);
endinterface

// ===== rtl/prl_rsp_if.sv =====
`timescale 1ns / 1ps

interface prl_rsp_if import prl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [KEY_W-1:0]    entry_key;
    logic [PAY_W-1:0]    entry_payload;
    logic [POS_W-1:0]    entry_count;
    logic                last;

    modport source (output valid, output status, output found_position,
                    output entry_key, output entry_payload, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input found_position,
                    input entry_key, input entry_payload, input entry_count,
                    input last, output ready);
endinterface

// ===== rtl/prl_cell.sv =====
`timescale 1ns / 1ps

module prl_cell import prl_pkg::*; #(
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  t_cell_op                i_op,
    input  logic [KEY_BITS-1:0]     i_new_key,
    input  logic [PAYLOAD_BITS-1:0] i_new_pay,
    input  logic [KEY_BITS-1:0]     i_left_key,
    input  logic [PAYLOAD_BITS-1:0] i_left_pay,
    input  logic [KEY_BITS-1:0]     i_right_key,
    input  logic [PAYLOAD_BITS-1:0] i_right_pay,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [PAYLOAD_BITS-1:0] o_pay,
    output logic                    o_gt
);

    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_HOLD: begin
                r_key <= r_key;
            end
            CELL_LOAD: begin
                r_key <= i_new_key;
                r_pay <= i_new_pay;
            end
            CELL_FROM_LEFT: begin
                r_key <= i_left_key;
                r_pay <= i_left_pay;
            end
            CELL_FROM_RIGHT: begin
                r_key <= i_right_key;
                r_pay <= i_right_pay;
            end
        endcase
    end

    assign o_key = r_key;
    assign o_pay = r_pay;
    // strict compare keeps equal keys in order during sort
    assign o_gt  = r_key > i_right_key;

endmodule

// ===== rtl/positional_record_list.sv =====
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY records (key + payload) held in a row of
// cells. One request at a time is taken, only while the block is idle; the
// result sits in an output register so the next request can be taken while it
// waits. Insert, a bad position, a full list and an empty readout finish after
// accept and execute, as the cells shift by one place in the execute step.
// Mode codes 6/7 are dropped in the accept cycle and give no result.
// Find, delete by key and delete at a position rotate the whole ring once past
// cell 0 to locate the entry. Sort runs CAPACITY odd-even transposition phases.
// Readout also rotates the ring once, one result per cycle while the output
// register is free, and holds the ring while the result side holds ready low.
// The other modes likewise wait in their result step while an earlier result
// is still held in the output register.

`include "assert_macros.svh"

module positional_record_list import prl_pkg::*; #(
    parameter int CAPACITY     = CAPACITY_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prl_req_if.sink   i_req,
    prl_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SORT,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [IW-1:0]           r_step, n_step;
    logic                    r_hit, n_hit;
    logic [MODE_W-1:0]       r_mode;
    logic [POS_W-1:0]        r_pos;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [IW-1:0]           r_idx;
    logic [KEY_BITS-1:0]     r_fkey;
    logic [PAYLOAD_BITS-1:0] r_fpay;

    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [POS_W-1:0]        r_out_pos;
    logic [KEY_W-1:0]        r_out_key;
    logic [PAY_W-1:0]        r_out_pay;
    logic [POS_W-1:0]        r_out_count;
    logic                    r_out_last;

    logic [KEY_BITS-1:0]     w_cell_key [CAPACITY];
    logic [PAYLOAD_BITS-1:0] w_cell_pay [CAPACITY];
    logic                    w_gt       [CAPACITY];
    logic                    w_swap     [CAPACITY];
    t_cell_op                w_cell_op  [CAPACITY];

    logic                    w_slot;
    logic                    w_accept;
    logic                    w_emit;
    t_status                 w_em_status;
    logic [POS_W-1:0]        w_em_pos;
    logic [KEY_W-1:0]        w_em_key;
    logic [PAY_W-1:0]        w_em_pay;
    logic                    w_em_last;
    logic                    w_inc, w_dec;
    logic                    w_capture;
    logic                    w_in_range;
    logic                    w_match;
    logic                    w_scan_end;
    logic [PW-1:0]           w_pos_m1;
    logic [PW-1:0]           w_step_p1;
    logic                    w_ins_bad, w_full, w_del_bad;

    // cell row, closed into a ring for rotation
    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        localparam int LEFT  = (j == 0) ? CAPACITY - 1 : j - 1;
        localparam int RIGHT = (j == CAPACITY - 1) ? 0 : j + 1;
        prl_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_cell_op[j]),
            .i_new_key   (r_key),
            .i_new_pay   (r_pay),
            .i_left_key  (w_cell_key[LEFT]),
            .i_left_pay  (w_cell_pay[LEFT]),
            .i_right_key (w_cell_key[RIGHT]),
            .i_right_pay (w_cell_pay[RIGHT]),
            .o_key       (w_cell_key[j]),
            .o_pay       (w_cell_pay[j]),
            .o_gt        (w_gt[j])
        );
    end

    assign w_slot     = !r_out_valid || o_rsp.ready;
    assign w_accept   = (r_state == S_IDLE) && i_req.valid;
    assign w_pos_m1   = PW'(r_pos) - PW'(1);
    assign w_step_p1  = PW'(r_step) + PW'(1);
    assign w_in_range = PW'(r_step) < PW'(r_count);
    assign w_scan_end = r_step == IW'(CAPACITY - 1);
    assign w_ins_bad  = (r_pos == '0) || (PW'(r_pos) > PW'(r_count) + PW'(1));
    assign w_full     = r_count == CW'(CAPACITY);
    assign w_del_bad  = (r_pos == '0) || (PW'(r_pos) > PW'(r_count));
    assign w_match    = (r_mode == MODE_DELETE_POS) ? (PW'(r_step) == w_pos_m1)
                                                    : (w_cell_key[0] == r_key);

    // odd-even transposition: pair (j, j+1) on phase parity, both in use
    always_comb begin
        for (int j = 0; j < CAPACITY; j++) begin
            w_swap[j] = (j < CAPACITY - 1) && (r_step[0] == 1'(j % 2))
                        && (PW'(j + 1) < PW'(r_count)) && w_gt[j];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_hit       = r_hit;
        w_emit      = 1'b0;
        w_em_status = ST_OK;
        w_em_pos    = '0;
        w_em_key    = '0;
        w_em_pay    = '0;
        w_em_last   = 1'b1;
        w_inc       = 1'b0;
        w_dec       = 1'b0;
        w_capture   = 1'b0;
        for (int j = 0; j < CAPACITY; j++) begin
            w_cell_op[j] = CELL_HOLD;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req.mode <= MODE_DELETE_KEY)) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot) begin
                    unique case (r_mode)
                        MODE_INSERT: begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (w_ins_bad) begin
                                w_em_status = ST_BADPOS;
                            end else if (w_full) begin
                                w_em_status = ST_FULL;
                            end else begin
                                w_em_pos = r_pos;
                                w_em_key = KEY_W'(r_key);
                                w_em_pay = PAY_W'(r_pay);
                                w_inc    = 1'b1;
                                for (int j = 0; j < CAPACITY; j++) begin
                                    if (PW'(j) > w_pos_m1) begin
                                        w_cell_op[j] = CELL_FROM_LEFT;
                                    end else if (PW'(j) == w_pos_m1) begin
                                        w_cell_op[j] = CELL_LOAD;
                                    end
                                end
                            end
                        end
                        MODE_DELETE_POS: begin
                            if (w_del_bad) begin
                                w_emit      = 1'b1;
                                w_em_status = ST_BADPOS;
                                n_state     = S_IDLE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        MODE_FIND, MODE_DELETE_KEY: begin
                            n_state = S_SCAN;
                        end
                        MODE_SORT: begin
                            n_state = S_SORT;
                        end
                        MODE_READ_ALL: begin
                            if (r_count == '0) begin
                                w_emit      = 1'b1;
                                w_em_status = ST_EMPTY;
                                n_state     = S_IDLE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // readout holds the ring while a result cannot be written
                if (!((r_mode == MODE_READ_ALL) && w_in_range && !w_slot)) begin
                    for (int j = 0; j < CAPACITY; j++) begin
                        w_cell_op[j] = CELL_FROM_RIGHT;
                    end
                    if (r_mode == MODE_READ_ALL) begin
                        if (w_in_range) begin
                            w_emit    = 1'b1;
                            w_em_pos  = POS_W'(w_step_p1);
                            w_em_key  = KEY_W'(w_cell_key[0]);
                            w_em_pay  = PAY_W'(w_cell_pay[0]);
                            w_em_last = w_step_p1 == PW'(r_count);
                        end
                    end else if (w_in_range && !r_hit && w_match) begin
                        n_hit     = 1'b1;
                        w_capture = 1'b1;
                    end
                    if (w_scan_end) begin
                        n_step  = '0;
                        n_state = (r_mode == MODE_READ_ALL) ? S_IDLE : S_DONE;
                    end else begin
                        n_step = r_step + IW'(1);
                    end
                end
            end
            S_SORT: begin
                for (int j = 0; j < CAPACITY; j++) begin
                    if (w_swap[j]) begin
                        w_cell_op[j] = CELL_FROM_RIGHT;
                    end else if ((j > 0) && w_swap[(j > 0) ? j - 1 : 0]) begin
                        w_cell_op[j] = CELL_FROM_LEFT;
                    end
                end
                if (w_scan_end) begin
                    n_step  = '0;
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + IW'(1);
                end
            end
            S_DONE: begin
                if (w_slot) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    n_hit   = 1'b0;
                    if (r_mode != MODE_SORT) begin
                        if (r_hit) begin
                            w_em_pos = POS_W'(PW'(r_idx) + PW'(1));
                            w_em_key = KEY_W'(r_fkey);
                            w_em_pay = PAY_W'(r_fpay);
                            if (r_mode != MODE_FIND) begin
                                w_dec = 1'b1;
                                for (int j = 0; j < CAPACITY; j++) begin
                                    if (PW'(j) >= PW'(r_idx)) begin
                                        w_cell_op[j] = CELL_FROM_RIGHT;
                                    end
                                end
                            end
                        end else begin
                            w_em_status = ST_NOKEY;
                        end
                    end
                end
            end
        endcase
    end

    assign n_count = r_count + CW'(w_inc) - CW'(w_dec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_hit   <= n_hit;
            if (w_accept) begin
                r_mode <= i_req.mode;
                r_pos  <= i_req.position;
                r_key  <= KEY_BITS'(i_req.key);
                r_pay  <= PAYLOAD_BITS'(i_req.payload);
            end
            if (w_capture) begin
                r_idx  <= r_step;
                r_fkey <= w_cell_key[0];
                r_fpay <= w_cell_pay[0];
            end
            if (w_emit) begin
                r_out_valid  <= 1'b1;
                r_out_status <= w_em_status;
                r_out_pos    <= w_em_pos;
                r_out_key    <= w_em_key;
                r_out_pay    <= w_em_pay;
                r_out_count  <= POS_W'(n_count);
                r_out_last   <= w_em_last;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_req.ready          = r_state == S_IDLE;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.found_position = r_out_pos;
    assign o_rsp.entry_key      = r_out_key;
    assign o_rsp.entry_payload  = r_out_pay;
    assign o_rsp.entry_count    = r_out_count;
    assign o_rsp.last           = r_out_last;

    `PRL_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `PRL_ASSERT_NEXT(a_count_moves, i_clk, i_rst_n, r_state != S_EXEC && r_state != S_DONE, r_count == $past(r_count))
    `PRL_ASSERT_IMP(a_ring_home, i_clk, i_rst_n, r_state == S_IDLE, r_step == '0 && !r_hit)
    `PRL_ASSERT_IMP(a_empty_count, i_clk, i_rst_n, r_out_valid && r_out_status == ST_EMPTY, r_out_count == '0)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import prl_pkg::*;

    localparam int SLOTS        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 480;

    // mode codes the block has no operation for
    localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd7;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
    } list_req_t;

    typedef struct {
        t_status          status;
        logic [POS_W-1:0] pos;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic [POS_W-1:0] count;
        logic             last;
    } list_rsp_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    prl_req_if req_bus ();
    prl_rsp_if rsp_bus ();

    positional_record_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the list contents
    logic [KEY_W-1:0] list_key [SLOTS];
    logic [PAY_W-1:0] list_pay [SLOTS];
    int               list_count = 0;
    int               peak_count = 0;

    list_req_t pend_q [$];
    list_rsp_t want_q [$];
    list_req_t on_bus;
    list_rsp_t due;

    int err_count = 0;
    int req_seen  = 0;
    int rsp_seen  = 0;
    int rand_n    = 0;
    int outcome_tally [5] = '{default: 0};
    bit calm      = 1'b0;
    bit hold_rsp  = 1'b0;

    task automatic report_mismatch(string what, longint got, longint want);
        if (err_count < 50)
            $display("%0t tb_top: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        err_count++;
    endtask

    function automatic void push_result(t_status st, int pos, logic [KEY_W-1:0] k,
                                        logic [PAY_W-1:0] v, bit fin);
        list_rsp_t r;
        r.status = st;
        r.pos    = POS_W'(pos);
        r.key    = k;
        r.pay    = v;
        r.count  = POS_W'(list_count);
        r.last   = fin;
        want_q.push_back(r);
    endfunction

    function automatic void drop_at(int idx);
        int i;
        for (i = idx; i + 1 < list_count; i++) begin
            list_key[i] = list_key[i + 1];
            list_pay[i] = list_pay[i + 1];
        end
        list_count--;
    endfunction

    // works out the results of one accepted request and updates the shadow list
    function automatic void apply_request(list_req_t r);
        int p, i, j, hit;
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] v;
        p = r.position;
        case (r.mode)
            MODE_INSERT: begin
                // position is checked before fullness
                if (p < 1 || p > list_count + 1) begin
                    push_result(ST_BADPOS, 0, '0, '0, 1'b1);
                end else if (list_count >= SLOTS) begin
                    push_result(ST_FULL, 0, '0, '0, 1'b1);
                end else begin
                    for (i = list_count; i >= p; i--) begin
                        list_key[i] = list_key[i - 1];
                        list_pay[i] = list_pay[i - 1];
                    end
                    list_key[p - 1] = r.key;
                    list_pay[p - 1] = r.payload;
                    list_count++;
                    push_result(ST_OK, p, r.key, r.payload, 1'b1);
                end
            end
            MODE_DELETE_POS: begin
                if (p < 1 || p > list_count) begin
                    push_result(ST_BADPOS, 0, '0, '0, 1'b1);
                end else begin
                    k = list_key[p - 1];
                    v = list_pay[p - 1];
                    drop_at(p - 1);
                    push_result(ST_OK, p, k, v, 1'b1);
                end
            end
            MODE_FIND, MODE_DELETE_KEY: begin
                hit = list_count;
                for (i = list_count - 1; i >= 0; i--)
                    if (list_key[i] == r.key) hit = i;
                if (hit >= list_count) begin
                    push_result(ST_NOKEY, 0, '0, '0, 1'b1);
                end else begin
                    k = list_key[hit];
                    v = list_pay[hit];
                    if (r.mode == MODE_DELETE_KEY) drop_at(hit);
                    push_result(ST_OK, hit + 1, k, v, 1'b1);
                end
            end
            MODE_SORT: begin
                // insertion sort keeps equal keys in their order
                for (i = 1; i < list_count; i++) begin
                    k = list_key[i];
                    v = list_pay[i];
                    j = i;
                    while (j > 0 && list_key[j - 1] > k) begin
                        list_key[j] = list_key[j - 1];
                        list_pay[j] = list_pay[j - 1];
                        j--;
                    end
                    list_key[j] = k;
                    list_pay[j] = v;
                end
                push_result(ST_OK, 0, '0, '0, 1'b1);
            end
            MODE_READ_ALL: begin
                if (list_count == 0) begin
                    push_result(ST_EMPTY, 0, '0, '0, 1'b1);
                end else begin
                    for (i = 0; i < list_count; i++)
                        push_result(ST_OK, i + 1, list_key[i], list_pay[i],
                                    i == list_count - 1);
                end
            end
            default: ;
        endcase
        if (list_count > peak_count) peak_count = list_count;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready) begin
                apply_request(on_bus);
                req_seen++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pend_q.size() > 0 && (calm || $urandom_range(0, 99) >= 18)) begin
                    on_bus = pend_q.pop_front();
                    req_bus.valid    <= 1'b1;
                    req_bus.mode     <= on_bus.mode;
                    req_bus.position <= on_bus.position;
                    req_bus.key      <= on_bus.key;
                    req_bus.payload  <= on_bus.payload;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (want_q.size() == 0) begin
                    report_mismatch("unexpected result", rsp_bus.status, 0);
                end else begin
                    due = want_q.pop_front();
                    rsp_seen++;
                    outcome_tally[due.status]++;
                    if (rsp_bus.status !== due.status)
                        report_mismatch("status", rsp_bus.status, due.status);
                    if (rsp_bus.found_position !== due.pos)
                        report_mismatch("found_position", rsp_bus.found_position, due.pos);
                    if (rsp_bus.entry_key !== due.key)
                        report_mismatch("entry_key", rsp_bus.entry_key, due.key);
                    if (rsp_bus.entry_payload !== due.pay)
                        report_mismatch("entry_payload", rsp_bus.entry_payload, due.pay);
                    if (rsp_bus.entry_count !== due.count)
                        report_mismatch("entry_count", rsp_bus.entry_count, due.count);
                    if (rsp_bus.last !== due.last)
                        report_mismatch("last", rsp_bus.last, due.last);
                end
            end
            rsp_bus.ready <= !hold_rsp && (calm || $urandom_range(0, 99) >= 18);
        end
    end

    // one long back-pressure window so the block fills and stalls its input
    initial begin : stall_window
        wait (rand_n >= 300);
        @(negedge i_clk);
        hold_rsp = 1'b1;
        repeat (60) @(negedge i_clk);
        hold_rsp = 1'b0;
    end

    initial begin : watchdog
        #10_000_000;
        $display("tb_top: timed out");
        $display("tb_top: done, errors");
        $finish;
    end

    // next request is built only once the previous one has been taken
    task automatic await_slot();
        do begin
            @(negedge i_clk);
        end while (pend_q.size() != 0 || req_bus.valid);
    endtask

    task automatic send(logic [MODE_W-1:0] m, int p, logic [KEY_W-1:0] k,
                        logic [PAY_W-1:0] v);
        list_req_t r;
        await_slot();
        r.mode     = m;
        r.position = POS_W'(p);
        r.key      = k;
        r.payload  = v;
        pend_q.push_back(r);
    endtask

    initial begin : stimulus
        int i, roll, ins_w, del_w, p;
        bit grow;
        logic [MODE_W-1:0] m;
        logic [KEY_W-1:0]  k;
        logic [PAY_W-1:0]  v;
        list_req_t r;

        i_rst_n          = 1'b0;
        req_bus.valid    = 1'b0;
        req_bus.mode     = MODE_INSERT;
        req_bus.position = '0;
        req_bus.key      = '0;
        req_bus.payload  = '0;
        rsp_bus.ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        send(MODE_READ_ALL, 0, '0, '0);
        send(MODE_DELETE_POS, 1, '0, '0);
        send(MODE_FIND, 0, '1, '0);
        send(MODE_DELETE_KEY, 0, '0, '0);
        send(MODE_SORT, 0, '0, '0);
        send(MODE_INSERT, 0, '1, '1);
        send(MODE_INSERT, 2, '1, '1);

        // fill to capacity: head, tail and middle inserts, duplicate keys
        for (i = 0; i < SLOTS; i++) begin
            p = (i % 3 == 0) ? 1 : (i % 3 == 1) ? i + 1 : i / 2 + 1;
            k = (i == 0) ? '1 : (i == 1) ? '0 : KEY_W'(i % 5);
            v = (i == 0) ? '0 : (i == 1) ? '1 : PAY_W'(16'h5a00 + i);
            send(MODE_INSERT, p, k, v);
        end
        send(MODE_INSERT, SLOTS + 1, 16'h0bad, 16'h0bad);
        send(MODE_INSERT, 31, 16'h0bad, 16'h0bad);
        send(MODE_RSVD_A, 1, '0, '0);
        send(MODE_RSVD_B, 1, '0, '0);
        send(MODE_FIND, 0, 16'h0002, '0);
        send(MODE_SORT, 0, '0, '0);
        send(MODE_READ_ALL, 0, '0, '0);
        send(MODE_DELETE_KEY, 0, 16'h0002, '0);
        send(MODE_DELETE_POS, SLOTS, '0, '0);
        send(MODE_DELETE_POS, SLOTS - 1, '0, '0);

        grow = 1'b1;
        while (rand_n < RANDOM_ITEMS) begin
            await_slot();
            calm = (rand_n >= 150 && rand_n < 230);
            if (rand_n % 64 == 0) grow = $urandom_range(0, 1);
            ins_w = grow ? 45 : 20;
            del_w = grow ? 12 : 30;
            roll = $urandom_range(0, 9);
            if (roll < 4)
                k = KEY_W'($urandom_range(0, 7));
            else if (roll == 4)
                k = '0;
            else if (roll == 5)
                k = '1;
            else
                k = KEY_W'($urandom);
            v = PAY_W'($urandom);
            p = 1;
            roll = $urandom_range(0, 99);
            if (roll < ins_w) begin
                m = MODE_INSERT;
                p = $urandom_range(1, list_count + 1);
            end else if (roll < ins_w + del_w) begin
                m = MODE_DELETE_POS;
                p = (list_count > 0) ? $urandom_range(1, list_count) : 1;
            end else if (roll < ins_w + del_w + 10) begin
                m = MODE_FIND;
                if (list_count > 0 && $urandom_range(0, 3) != 0)
                    k = list_key[$urandom_range(0, list_count - 1)];
            end else if (roll < ins_w + del_w + 18) begin
                m = MODE_DELETE_KEY;
                if (list_count > 0 && $urandom_range(0, 3) != 0)
                    k = list_key[$urandom_range(0, list_count - 1)];
            end else if (roll < ins_w + del_w + 23) begin
                m = MODE_SORT;
            end else if (roll < ins_w + del_w + 28) begin
                m = MODE_READ_ALL;
            end else begin
                // noise: any mode code, any position
                m = MODE_W'($urandom_range(0, 7));
                p = $urandom_range(0, 31);
            end
            r.mode     = m;
            r.position = POS_W'(p);
            r.key      = k;
            r.payload  = v;
            pend_q.push_back(r);
            if (m != MODE_RSVD_A && m != MODE_RSVD_B) rand_n++;
        end
        calm = 1'b0;

        await_slot();
        do begin
            @(negedge i_clk);
        end while (want_q.size() != 0);
        repeat (SLOTS + 8) @(negedge i_clk);
        if (want_q.size() != 0)
            report_mismatch("results never delivered", want_q.size(), 0);

        $display("tb_top: %0d requests, %0d results compared; list held up to %0d of %0d",
                 req_seen, rsp_seen, peak_count, SLOTS);
        $display("tb_top: ok %0d, bad position %0d, full %0d, key missing %0d, empty %0d",
                 outcome_tally[ST_OK], outcome_tally[ST_BADPOS], outcome_tally[ST_FULL],
                 outcome_tally[ST_NOKEY], outcome_tally[ST_EMPTY]);
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== positional_record_list.f =====
+incdir+rtl
rtl/prl_pkg.sv
rtl/prl_req_if.sv
rtl/prl_rsp_if.sv
rtl/prl_cell.sv
rtl/positional_record_list.sv
tb/sv/tb_top.sv
